// ----- rtl/puid_pkg.sv -----
// shared types and constants for the operator uid policy line parser
package puid_pkg;

    // line phase codes
    localparam logic [2:0] PH_LEAD      = 3'd0;
    localparam logic [2:0] PH_KEY       = 3'd1;
    localparam logic [2:0] PH_AFTER_KEY = 3'd2;
    localparam logic [2:0] PH_PRE_VALUE = 3'd3;
    localparam logic [2:0] PH_DIGITS    = 3'd4;
    localparam logic [2:0] PH_TRAIL     = 3'd5;
    localparam logic [2:0] PH_IGNORE    = 3'd6;

    // verdict codes
    localparam logic [1:0] VERDICT_GRANTED   = 2'd0;
    localparam logic [1:0] VERDICT_MALFORMED = 2'd1;
    localparam logic [1:0] VERDICT_MISMATCH  = 2'd2;

    // register index of the requester uid (word address bit 2)
    localparam logic REG_REQUESTER_UID = 1'b0;

    // key and value widths
    localparam int          KEY_LEN  = 12;
    localparam int          ACC_W    = 44;
    localparam int          UID_W    = 45;
    localparam logic [43:0] UID_LIMIT = 44'h100_0000_0000;

    // byte codes
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // parser state carried from byte to byte
    typedef struct packed {
        logic [2:0]       phase;
        logic [3:0]       key_pos;
        logic [ACC_W-1:0] acc;
        logic             digit_seen;
        logic             key_found;
        logic [ACC_W-1:0] stored_uid;
        logic             malformed;
    } parse_state_t;

    // characters of the operator key, one per position
    function automatic logic [7:0] key_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = 8'h6F; // o
            4'd1:    c = 8'h70; // p
            4'd2:    c = 8'h65; // e
            4'd3:    c = 8'h72; // r
            4'd4:    c = 8'h61; // a
            4'd5:    c = 8'h74; // t
            4'd6:    c = 8'h6F; // o
            4'd7:    c = 8'h72; // r
            4'd8:    c = 8'h5F; // _
            4'd9:    c = 8'h75; // u
            4'd10:   c = 8'h69; // i
            4'd11:   c = 8'h64; // d
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/policy_uid_line_parser.sv -----
// top level of the operator uid policy line parser
// The block takes a policy text one byte per transfer and looks for a single
// operator key line of the form key = N. It accepts one item every clock cycle
// while the input register is not held; a byte goes through the input register and
// the per-byte parse logic into the state and result registers, so the verdict is
// registered as the last item leaves the input register. Only a last item waits
// for the result register to be free.
// One result is given for each text, on its last item: granted when the parsed
// uid equals the requester uid register, mismatch when it differs, malformed
// (uid all ones) on any parse error, missing key or a text of MAX_BYTES or more
// bytes. All parse state returns to reset after each result; the requester uid
// is kept.
module policy_uid_line_parser #(
    parameter int MAX_BYTES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  text_byte,
    input  logic        has_byte,
    input  logic        last,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  verdict,
    output logic signed [44:0] parsed_uid
);

    localparam int CNT_W = $clog2(MAX_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BYTES);

    logic [31:0]             requester_uid_reg;
    logic                    s1_valid_reg, s1_valid_next;
    logic [7:0]              s1_byte_reg;
    logic                    s1_has_reg;
    logic                    s1_last_reg;
    puid_pkg::parse_state_t  state_reg, state_next, st;
    logic [CNT_W-1:0]        cnt_reg, cnt_next, cnt;
    logic                    out_valid_reg, out_valid_next;
    logic [1:0]              verdict_reg, verdict_next;
    logic [44:0]             uid_reg, uid_next;
    logic                    out_free, advance, accept, cfg_write;

    function automatic logic is_blank(input logic [7:0] b);
        return (b == puid_pkg::CH_SPACE) || (b == puid_pkg::CH_TAB);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= puid_pkg::CH_ZERO) && (b <= puid_pkg::CH_NINE);
    endfunction

    // close the current line at a newline or at the end of the text
    function automatic puid_pkg::parse_state_t line_end(input puid_pkg::parse_state_t s);
        puid_pkg::parse_state_t r;
        r = s;
        if (s.phase == puid_pkg::PH_PRE_VALUE) begin
            r.malformed = 1'b1;
        end
        else if (s.phase == puid_pkg::PH_DIGITS || s.phase == puid_pkg::PH_TRAIL) begin
            if (!s.digit_seen || s.key_found) begin
                r.malformed = 1'b1;
            end
            else begin
                r.stored_uid = s.acc;
                r.key_found  = 1'b1;
            end
        end
        r.phase      = puid_pkg::PH_LEAD;
        r.key_pos    = 4'd0;
        r.acc        = '0;
        r.digit_seen = 1'b0;
        return r;
    endfunction

    // one data byte through the line parser
    function automatic puid_pkg::parse_state_t take_byte(input puid_pkg::parse_state_t s,
                                                         input logic [7:0] b);
        puid_pkg::parse_state_t r;
        r = s;
        if (b == puid_pkg::CH_NL) begin
            r = line_end(s);
        end
        else begin
            case (s.phase)
                puid_pkg::PH_LEAD:
                begin
                    if (!is_blank(b)) begin
                        if (b == puid_pkg::key_char(4'd0)) begin
                            r.phase   = puid_pkg::PH_KEY;
                            r.key_pos = 4'd1;
                        end
                        else begin
                            r.phase = puid_pkg::PH_IGNORE;
                        end
                    end
                end
                puid_pkg::PH_KEY:
                begin
                    if (s.key_pos < 4'(puid_pkg::KEY_LEN) && b == puid_pkg::key_char(s.key_pos))
                    begin
                        r.key_pos = s.key_pos + 4'd1;
                        if (r.key_pos >= 4'(puid_pkg::KEY_LEN)) begin
                            r.phase = puid_pkg::PH_AFTER_KEY;
                        end
                    end
                    else begin
                        r.phase = puid_pkg::PH_IGNORE;
                    end
                end
                puid_pkg::PH_AFTER_KEY:
                begin
                    if (b == puid_pkg::CH_EQ) begin
                        r.phase = puid_pkg::PH_PRE_VALUE;
                    end
                    else if (!is_blank(b)) begin
                        r.phase = puid_pkg::PH_IGNORE;
                    end
                end
                puid_pkg::PH_PRE_VALUE, puid_pkg::PH_DIGITS:
                begin
                    if (s.phase == puid_pkg::PH_PRE_VALUE && is_blank(b)) begin
                        r = s;
                    end
                    else if (is_digit(b)) begin
                        if (s.acc > puid_pkg::UID_LIMIT) begin
                            r.malformed = 1'b1;
                        end
                        else begin
                            // acc is at most 2^40 here, so acc*10+9 fits in 44 bits
                            r.acc = (s.acc << 3) + (s.acc << 1)
                                  + {{(puid_pkg::ACC_W-4){1'b0}}, b[3:0]};
                            r.digit_seen = 1'b1;
                            r.phase      = puid_pkg::PH_DIGITS;
                        end
                    end
                    else if (s.phase == puid_pkg::PH_DIGITS &&
                             (is_blank(b) || b == puid_pkg::CH_CR)) begin
                        r.phase = puid_pkg::PH_TRAIL;
                    end
                    else begin
                        r.malformed = 1'b1;
                    end
                end
                puid_pkg::PH_TRAIL:
                begin
                    if (!is_blank(b) && b != puid_pkg::CH_CR) begin
                        r.malformed = 1'b1;
                    end
                end
                default:
                begin
                    r = s;
                end
            endcase
        end
        return r;
    endfunction

    // configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == puid_pkg::REG_REQUESTER_UID) ? requester_uid_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            requester_uid_reg <= 32'd0;
        end
        else if (cfg_write && paddr[2] == puid_pkg::REG_REQUESTER_UID) begin
            requester_uid_reg <= pwdata;
        end
    end

    // handshake: only a last item needs the result register
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    end

    // per-byte parse and end-of-text verdict
    always_comb
    begin
        st           = state_reg;
        cnt          = cnt_reg;
        verdict_next = verdict_reg;
        uid_next     = uid_reg;
        if (s1_has_reg) begin
            if (cnt < CNT_MAX) begin
                cnt = cnt + 1'b1;
            end
            if (cnt >= CNT_MAX) begin
                st.malformed = 1'b1;
            end
            if (!st.malformed) begin
                st = take_byte(st, s1_byte_reg);
            end
        end
        if (s1_last_reg) begin
            if (!st.malformed) begin
                st = line_end(st);
            end
            if (st.malformed || !st.key_found) begin
                verdict_next = puid_pkg::VERDICT_MALFORMED;
                uid_next     = '1;
            end
            else begin
                verdict_next = (st.stored_uid == {12'd0, requester_uid_reg})
                             ? puid_pkg::VERDICT_GRANTED : puid_pkg::VERDICT_MISMATCH;
                uid_next     = {1'b0, st.stored_uid};
            end
            st  = '0;
            cnt = '0;
        end
        state_next = advance ? st : state_reg;
        cnt_next   = advance ? cnt : cnt_reg;
    end

    // result register valid
    always_comb
    begin
        if (advance && s1_last_reg) begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall) begin
            out_valid_next = 1'b0;
        end
        else begin
            out_valid_next = out_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            state_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            s1_valid_reg  <= s1_valid_next;
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept) begin
            s1_byte_reg <= text_byte;
            s1_has_reg  <= has_byte;
            s1_last_reg <= last;
        end
        if (advance && s1_last_reg) begin
            verdict_reg <= verdict_next;
            uid_reg     <= uid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign verdict    = verdict_reg;
    assign parsed_uid = signed'(uid_reg);

endmodule

// ----- rtl/puid_checker.sv -----
// port-level checks for the operator uid policy line parser, with bind
module puid_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  verdict,
    input logic [44:0] parsed_uid
);

    // a stalled result transfer holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(verdict) && $stable(parsed_uid))
        else $error("stalled result changed");

    // malformed results carry an all-ones uid
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && verdict == puid_pkg::VERDICT_MALFORMED |-> parsed_uid == '1)
        else $error("malformed verdict without all-ones uid");

    // a granted uid matched a 32-bit requester uid
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && verdict == puid_pkg::VERDICT_GRANTED |-> parsed_uid[44:32] == 13'd0)
        else $error("granted uid wider than requester uid");

    // a non-malformed result has a valid verdict code and a uid that is never negative
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && verdict != puid_pkg::VERDICT_MALFORMED |->
            (verdict == puid_pkg::VERDICT_GRANTED || verdict == puid_pkg::VERDICT_MISMATCH)
            && !parsed_uid[44])
        else $error("bad verdict code or negative uid");

endmodule

bind policy_uid_line_parser puid_checker u_puid_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .verdict    (verdict),
    .parsed_uid (parsed_uid)
);

// ----- bench/policy_uid_line_parser_tb.sv -----
`timescale 1ns / 100ps
// self-checking testbench for the operator uid policy line parser
module policy_uid_line_parser_tb;

    localparam int BYTE_LIMIT     = 4096;
    localparam int QUIET_LIMIT    = 2000;
    localparam int RESULT_LATENCY = 4;
    localparam int PHASE_ITEMS    = 180;
    localparam logic REG_UNUSED   = 1'b1;
    localparam logic [8*puid_pkg::KEY_LEN-1:0] KEY_WORD = {"operator", "_uid"};
    localparam logic [7:0] CH_HASH = 8'h23;

    // kinds of policy lines the random texts are made of
    typedef enum {
        LN_KEY, LN_MISSING_VALUE, LN_BAD_VALUE, LN_TRAILING, LN_OVERFLOW,
        LN_COMMENT, LN_BLANK, LN_OTHER, LN_PARTIAL_KEY, LN_KEY_NO_EQ, LN_NOISE
    } line_kind_t;

    typedef struct packed {
        logic [1:0]                 verdict;
        logic [puid_pkg::UID_W-1:0] uid;
    } policy_result_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  text_byte;
    logic        has_byte;
    logic        last;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  verdict;
    logic signed [44:0] parsed_uid;

    // parser model state
    logic [2:0]                 pol_phase;
    logic [3:0]                 pol_key_pos;
    logic [puid_pkg::ACC_W-1:0] pol_acc;
    logic                       pol_digit_seen;
    logic                       pol_key_found;
    logic [puid_pkg::ACC_W-1:0] pol_uid;
    logic                       pol_bad;
    int                         pol_count;
    logic [31:0]                caller_model;

    policy_result_t expected_verdicts[$];
    policy_result_t oldest;
    logic [7:0]     text_buf[$];
    int             data_items;
    int             fail_count;
    int             quiet_cycles;
    int             hold_request;
    bit             idling_on;

    policy_uid_line_parser #(
        .MAX_BYTES(BYTE_LIMIT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .text_byte(text_byte),
        .has_byte(has_byte),
        .last(last),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .verdict(verdict),
        .parsed_uid(parsed_uid)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // parser model
    // ---------------------------------------------------------------

    function automatic logic [7:0] key_byte(input int pos);
        return KEY_WORD[8*(puid_pkg::KEY_LEN-1-pos) +: 8];
    endfunction

    task automatic clear_policy_model();
        pol_phase      = puid_pkg::PH_LEAD;
        pol_key_pos    = '0;
        pol_acc        = '0;
        pol_digit_seen = 1'b0;
        pol_key_found  = 1'b0;
        pol_uid        = '0;
        pol_bad        = 1'b0;
        pol_count      = 0;
    endtask

    // end of line, by newline or by end of text
    task automatic close_policy_line();
        if (pol_phase == puid_pkg::PH_PRE_VALUE)
        begin
            pol_bad = 1'b1;
        end
        else if (pol_phase == puid_pkg::PH_DIGITS || pol_phase == puid_pkg::PH_TRAIL)
        begin
            if (!pol_digit_seen || pol_key_found)
                pol_bad = 1'b1;
            else
            begin
                pol_uid       = pol_acc;
                pol_key_found = 1'b1;
            end
        end
        pol_phase      = puid_pkg::PH_LEAD;
        pol_key_pos    = '0;
        pol_acc        = '0;
        pol_digit_seen = 1'b0;
    endtask

    task automatic parse_policy_byte(input logic [7:0] b);
        logic blank;
        logic digit;
        blank = (b == puid_pkg::CH_SPACE) || (b == puid_pkg::CH_TAB);
        digit = (b >= puid_pkg::CH_ZERO) && (b <= puid_pkg::CH_NINE);
        if (b == puid_pkg::CH_NL)
            close_policy_line();
        else
        begin
            case (pol_phase)
                puid_pkg::PH_LEAD:
                    if (!blank)
                    begin
                        if (b == key_byte(0))
                        begin
                            pol_phase   = puid_pkg::PH_KEY;
                            pol_key_pos = 4'd1;
                        end
                        else
                            pol_phase = puid_pkg::PH_IGNORE;
                    end
                puid_pkg::PH_KEY:
                    if (pol_key_pos < puid_pkg::KEY_LEN && b == key_byte(pol_key_pos))
                    begin
                        pol_key_pos = pol_key_pos + 4'd1;
                        if (pol_key_pos >= puid_pkg::KEY_LEN)
                            pol_phase = puid_pkg::PH_AFTER_KEY;
                    end
                    else
                        pol_phase = puid_pkg::PH_IGNORE;
                puid_pkg::PH_AFTER_KEY:
                    if (b == puid_pkg::CH_EQ)
                        pol_phase = puid_pkg::PH_PRE_VALUE;
                    else if (!blank)
                        pol_phase = puid_pkg::PH_IGNORE;
                puid_pkg::PH_PRE_VALUE, puid_pkg::PH_DIGITS:
                    if (!(pol_phase == puid_pkg::PH_PRE_VALUE && blank))
                    begin
                        if (digit)
                        begin
                            // a further digit above the ceiling spoils the value
                            if (pol_acc > puid_pkg::UID_LIMIT)
                                pol_bad = 1'b1;
                            else
                            begin
                                pol_acc        = pol_acc * 44'd10
                                               + 44'(b - puid_pkg::CH_ZERO);
                                pol_digit_seen = 1'b1;
                                pol_phase      = puid_pkg::PH_DIGITS;
                            end
                        end
                        else if (pol_phase == puid_pkg::PH_DIGITS
                                 && (blank || b == puid_pkg::CH_CR))
                            pol_phase = puid_pkg::PH_TRAIL;
                        else
                            pol_bad = 1'b1;
                    end
                puid_pkg::PH_TRAIL:
                    if (!blank && b != puid_pkg::CH_CR)
                        pol_bad = 1'b1;
                default: ;
            endcase
        end
    endtask

    // update the model for one accepted transfer, queue the verdict on last
    task automatic track_policy_item(input logic [7:0] b, input logic h, input logic l);
        policy_result_t r;
        if (h)
        begin
            if (pol_count < BYTE_LIMIT)
                pol_count++;
            if (pol_count >= BYTE_LIMIT)
                pol_bad = 1'b1;
            if (!pol_bad)
                parse_policy_byte(b);
        end
        if (l)
        begin
            if (!pol_bad)
                close_policy_line();
            if (pol_bad || !pol_key_found)
            begin
                r.verdict = puid_pkg::VERDICT_MALFORMED;
                r.uid     = '1;
            end
            else
            begin
                r.verdict = (pol_uid == {12'd0, caller_model})
                          ? puid_pkg::VERDICT_GRANTED : puid_pkg::VERDICT_MISMATCH;
                r.uid     = {1'b0, pol_uid};
            end
            expected_verdicts.push_back(r);
            clear_policy_model();
        end
    endtask

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------

    // one input transfer, with an occasional gap before it
    task automatic send_item(input logic [7:0] b, input logic h, input logic l);
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        text_byte <= b;
        has_byte  <= h;
        last      <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        track_policy_item(b, h, l);
        if (h)
            data_items++;
    endtask

    // send the buffered text, ending on its last byte or on a bare end marker
    task automatic send_text(input bit bare_end, input bit with_markers);
        int n;
        n = text_buf.size();
        for (int i = 0; i < n; i++)
        begin
            if (with_markers && $urandom_range(0, 7) == 0)
                send_item(8'($urandom), 1'b0, 1'b0);
            send_item(text_buf[i], 1'b1, !bare_end && i == n - 1);
        end
        if (bare_end || n == 0)
            send_item(8'($urandom), 1'b0, 1'b1);
        text_buf.delete();
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (RESULT_LATENCY) @(posedge clk);
    endtask

    // register write: setup cycle, then access cycle
    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == puid_pkg::REG_REQUESTER_UID)
            caller_model = value;
    endtask

    // ---------------------------------------------------------------
    // text builders
    // ---------------------------------------------------------------

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endtask

    task automatic add_key();
        for (int i = 0; i < puid_pkg::KEY_LEN; i++)
            text_buf.push_back(key_byte(i));
    endtask

    task automatic add_blanks();
        repeat ($urandom_range(0, 2))
            text_buf.push_back($urandom_range(0, 1) ? puid_pkg::CH_SPACE : puid_pkg::CH_TAB);
    endtask

    function automatic logic [7:0] printable();
        return 8'($urandom_range(33, 126));
    endfunction

    // decimal uid, often the caller's own, sometimes with a leading zero
    task automatic add_value();
        logic [63:0] v;
        case ($urandom_range(0, 5))
            0, 1:    v = {32'd0, caller_model};
            2:       v = {32'd0, caller_model} + 64'd1;
            3:       v = {32'd0, $urandom};
            4:       v = {$urandom, $urandom} % 64'd10995116277770;
            default: v = 64'($urandom_range(0, 999));
        endcase
        if ($urandom_range(0, 7) == 0)
            text_buf.push_back(puid_pkg::CH_ZERO);
        add_str($sformatf("%0d", v));
    endtask

    task automatic add_line(input line_kind_t kind);
        logic [7:0] c;
        int n;
        add_blanks();
        case (kind)
            LN_COMMENT:
            begin
                text_buf.push_back(CH_HASH);
                repeat ($urandom_range(0, 10)) text_buf.push_back(printable());
            end
            LN_BLANK:
                if ($urandom_range(0, 1))
                    text_buf.push_back(puid_pkg::CH_CR);
            LN_OTHER:
            begin
                do
                    c = printable();
                while (c == key_byte(0));
                text_buf.push_back(c);
                repeat ($urandom_range(0, 10)) text_buf.push_back(printable());
            end
            LN_PARTIAL_KEY:
            begin
                n = $urandom_range(1, puid_pkg::KEY_LEN - 1);
                for (int i = 0; i < n; i++)
                    text_buf.push_back(key_byte(i));
                text_buf.push_back("X");
                repeat ($urandom_range(0, 6)) text_buf.push_back(printable());
            end
            LN_KEY_NO_EQ:
            begin
                add_key();
                add_blanks();
                text_buf.push_back(":");
                add_value();
            end
            LN_NOISE:
                repeat ($urandom_range(1, 12)) text_buf.push_back(8'($urandom));
            default:
            begin
                // key line, well formed or broken after the '='
                add_key();
                add_blanks();
                text_buf.push_back(puid_pkg::CH_EQ);
                add_blanks();
                case (kind)
                    LN_KEY, LN_TRAILING:
                    begin
                        add_value();
                        repeat ($urandom_range(0, 2))
                            text_buf.push_back($urandom_range(0, 1) ? puid_pkg::CH_SPACE
                                                                    : puid_pkg::CH_CR);
                        if (kind == LN_TRAILING)
                            text_buf.push_back("x");
                    end
                    LN_BAD_VALUE:
                    begin
                        do
                            c = 8'($urandom);
                        while ((c >= puid_pkg::CH_ZERO && c <= puid_pkg::CH_NINE)
                               || c == puid_pkg::CH_SPACE || c == puid_pkg::CH_TAB
                               || c == puid_pkg::CH_NL);
                        text_buf.push_back(c);
                        add_value();
                    end
                    LN_OVERFLOW:
                        repeat ($urandom_range(14, 16))
                            text_buf.push_back(puid_pkg::CH_ZERO + 8'($urandom_range(1, 9)));
                    default: ;
                endcase
            end
        endcase
        text_buf.push_back(puid_pkg::CH_NL);
    endtask

    // a few lines, mostly one valid key among filler lines
    task automatic build_random_text();
        line_kind_t k;
        int n_lines;
        int key_line;
        bit with_key;
        n_lines  = $urandom_range(1, 4);
        key_line = $urandom_range(0, n_lines - 1);
        with_key = $urandom_range(0, 9) != 0;
        for (int i = 0; i < n_lines; i++)
        begin
            if (with_key && i == key_line)
                k = LN_KEY;
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1:    k = LN_COMMENT;
                    2:       k = LN_BLANK;
                    3, 4:    k = LN_OTHER;
                    5, 6:    k = LN_PARTIAL_KEY;
                    7:       k = LN_KEY_NO_EQ;
                    default: k = LN_NOISE;
                endcase
            end
            add_line(k);
        end
        // occasional repeated or broken key line
        case ($urandom_range(0, 11))
            0:       add_line(LN_KEY);
            1:       add_line(line_kind_t'($urandom_range(LN_MISSING_VALUE, LN_OVERFLOW)));
            default: ;
        endcase
        // text often ends without a final newline
        if ($urandom_range(0, 2) == 0 && text_buf[$] == puid_pkg::CH_NL)
            void'(text_buf.pop_back());
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    task automatic test_after_reset();
        add_key();
        add_str("=0\n");
        send_text(1'b0, 1'b0);
        add_key();
        add_str("=1");
        send_text(1'b0, 1'b0);
    endtask

    task automatic test_key_line_layout();
        add_str("  \t");
        add_key();
        add_str(" \t=\t 17");
        text_buf.push_back(puid_pkg::CH_CR);
        text_buf.push_back(puid_pkg::CH_NL);
        send_text(1'b0, 1'b0);
        add_str("\t ");
        add_key();
        add_str("= 42 \t");
        send_text(1'b0, 1'b0);
    endtask

    task automatic test_ignored_lines();
        add_str("\n# ");
        add_key();
        add_str("=3\n  \nuid=4\n");
        add_key();
        add_str(" 5\n");
        add_str("operatorXuid=6\n");
        add_key();
        add_str("=8\n");
        send_text(1'b0, 1'b0);
        // nothing but a comment: no key at all
        add_str("#only a comment\n");
        send_text(1'b0, 1'b0);
    endtask

    task automatic test_value_errors();
        add_key();
        add_str("=\n");
        send_text(1'b0, 1'b0);
        add_key();
        add_str(" =  ");
        send_text(1'b1, 1'b0);
        add_key();
        add_str("=12a\n");
        send_text(1'b0, 1'b0);
        add_key();
        add_str("=-1\n");
        send_text(1'b0, 1'b0);
        // value at the ceiling still takes one more digit, above it does not
        add_key();
        add_str("=10995116277760\n");
        send_text(1'b0, 1'b0);
        add_key();
        add_str("=10995116277770\n");
        send_text(1'b0, 1'b0);
        add_key();
        add_str("=5 x\n");
        send_text(1'b0, 1'b0);
        add_key();
        add_str("=5\n");
        add_key();
        add_str("=5\n");
        send_text(1'b0, 1'b0);
        // error sticks over a later good line
        add_key();
        add_str("=x\n");
        add_key();
        add_str("=5\n");
        send_text(1'b0, 1'b0);
    endtask

    task automatic test_text_endings();
        send_text(1'b1, 1'b0);
        add_key();
        add_str(" = 3");
        send_text(1'b1, 1'b1);
        add_key();
        add_str("=0\n#tail");
        send_text(1'b0, 1'b1);
        wait_for_results();
    endtask

    task automatic test_caller_register();
        write_reg(puid_pkg::REG_REQUESTER_UID, 32'hFFFF_FFFF);
        add_key();
        add_str("=4294967295");
        send_text(1'b0, 1'b0);
        add_key();
        add_str("=4294967296\n");
        send_text(1'b0, 1'b0);
        wait_for_results();
        // a write to an unused index leaves the requester uid alone
        write_reg(REG_UNUSED, 32'd123);
        add_key();
        add_str("=123");
        send_text(1'b0, 1'b0);
        add_key();
        add_str("=4294967295");
        send_text(1'b0, 1'b0);
        wait_for_results();
        write_reg(puid_pkg::REG_REQUESTER_UID, 32'd0);
        add_key();
        add_str("=000");
        send_text(1'b0, 1'b0);
        wait_for_results();
        write_reg(puid_pkg::REG_REQUESTER_UID, 32'd1000);
    endtask

    // receiver holds off while short texts keep coming
    task automatic test_output_backpressure();
        hold_request = 200;
        for (int i = 0; i < 24; i++)
        begin
            if (i % 2 == 1)
            begin
                add_key();
                add_str("=1000");
            end
            else
                text_buf.push_back(CH_HASH);
            send_text(1'b0, 1'b0);
        end
        wait_for_results();
    endtask

    task automatic test_random_texts();
        logic [31:0] caller;
        int goal;
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                1:       caller = '0;
                2:       caller = '1;
                default: caller = $urandom;
            endcase
            write_reg(puid_pkg::REG_REQUESTER_UID, caller);
            // the final phase runs without idling
            idling_on = (p < 3);
            goal = data_items + PHASE_ITEMS;
            while (data_items < goal)
            begin
                build_random_text();
                send_text($urandom_range(0, 9) == 0, $urandom_range(0, 5) == 0);
            end
            wait_for_results();
        end
    endtask

    // ---------------------------------------------------------------
    // receiver stall, result check, watchdog
    // ---------------------------------------------------------------

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_request) @(posedge clk);
                hold_request = 0;
                out_stall <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // compare each result transfer with the oldest pending verdict
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_verdicts.size() == 0)
            begin
                $display("%0t: result with no text pending, verdict %0d uid 'h%0h",
                         $time, verdict, parsed_uid);
                fail_count++;
            end
            else
            begin
                oldest = expected_verdicts.pop_front();
                if (verdict !== oldest.verdict)
                begin
                    $display("%0t: verdict expected %0d, got %0d",
                             $time, oldest.verdict, verdict);
                    fail_count++;
                end
                if (parsed_uid !== oldest.uid)
                begin
                    $display("%0t: parsed_uid expected 'h%0h, got 'h%0h",
                             $time, oldest.uid, parsed_uid);
                    fail_count++;
                end
            end
        end
    end

    // end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------

    initial
    begin
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_valid     = 1'b0;
        text_byte    = '0;
        has_byte     = 1'b0;
        last         = 1'b0;
        data_items   = 0;
        fail_count   = 0;
        quiet_cycles = 0;
        hold_request = 0;
        idling_on    = 1'b1;
        caller_model = '0;
        clear_policy_model();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_after_reset();
        test_key_line_layout();
        test_ignored_lines();
        test_value_errors();
        test_text_endings();
        test_caller_register();
        test_output_backpressure();
        test_random_texts();

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
